FILE: src/fpa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free page extent allocator package
// Sizes, result codes, controller states and the command/status structs.
// ---------------------------------------------------------------------------
package fpa_pkg;

    localparam int MAX_EXTENTS      = 64;
    localparam int PAGE_NUMBER_BITS = 20;
    localparam int END_BITS         = PAGE_NUMBER_BITS + 1;
    localparam int IDX_W            = $clog2(MAX_EXTENTS);
    localparam int CNT_W            = $clog2(MAX_EXTENTS + 1);
    localparam int ENTRY_W          = PAGE_NUMBER_BITS + END_BITS;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [PAGE_NUMBER_BITS-1:0] b;
        logic [END_BITS-1:0]         e;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_EVAL,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PLACE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CUR_INC,
        WR_CUR_BEGIN,
        WR_PREV_END,
        WR_CUR_END,
        WR_MOVE,
        WR_NEW
    } t_wr_sel;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_IDX,
        POS_IDX1
    } t_pos_sel;

    typedef struct packed {
        logic       load;
        logic       fetch_first;
        logic       fetch_next;
        logic       set_grant;
        logic       set_status;
        logic [1:0] status_code;
        logic       set_pos;
        t_pos_sel   pos_sel;
        logic       start_up;
        logic       start_down;
        logic       move_rd;
        logic       step_k;
        t_wr_sel    wr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
    } t_cmd;

    typedef struct packed {
        logic alloc;
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic idx_last;
        logic below_first;
        logic below_adj;
        logic empties;
        logic gap_hit;
        logic prev_end_eq;
        logic cur_right_adj;
        logic cur_end_eq;
        logic move_done;
        logic dir_up;
    } t_flags;

endpackage

FILE: src/fpa_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free page extent allocator channels
// Request and response valid/ready channels.
// ---------------------------------------------------------------------------
interface fpa_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic [fpa_pkg::PAGE_NUMBER_BITS-1:0] page_number;

    modport source (output valid, output operation, output page_number, input ready);
    modport sink   (input valid, input operation, input page_number, output ready);
endinterface

interface fpa_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [fpa_pkg::PAGE_NUMBER_BITS-1:0] granted_page;
    logic [1:0]                           status;
    logic [fpa_pkg::CNT_W-1:0]            extents_in_use;

    modport source (output valid, output granted_page, output status, output extents_in_use,
                    input ready);
    modport sink   (input valid, input granted_page, input status, input extents_in_use,
                    output ready);
endinterface

FILE: src/fpa_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

FILE: src/fpa_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free page extent allocator datapath
// Extent table, scan index, shift pointer, count and result registers.
// ---------------------------------------------------------------------------
module fpa_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fpa_pkg::t_cmd                        i_cmd,
    input  logic                                 i_operation,
    input  logic [fpa_pkg::PAGE_NUMBER_BITS-1:0] i_page_number,
    output fpa_pkg::t_flags                      o_flags,
    output logic [fpa_pkg::PAGE_NUMBER_BITS-1:0] o_granted_page,
    output logic [1:0]                           o_status,
    output logic [fpa_pkg::CNT_W-1:0]            o_extents_in_use
);
    logic                                 r_op;
    logic [fpa_pkg::PAGE_NUMBER_BITS-1:0] r_pg;
    logic [fpa_pkg::IDX_W-1:0]            r_idx;
    logic [fpa_pkg::IDX_W-1:0]            r_k;
    logic [fpa_pkg::IDX_W-1:0]            r_pos;
    logic                                 r_dir_up;
    logic [fpa_pkg::CNT_W-1:0]            r_count;
    fpa_pkg::t_entry                      r_prev;
    logic [fpa_pkg::PAGE_NUMBER_BITS-1:0] r_grant;
    logic [1:0]                           r_status;

    fpa_pkg::t_entry                      cur;
    logic [fpa_pkg::ENTRY_W-1:0]          rd_data;
    logic                                 rd_en;
    logic [fpa_pkg::IDX_W-1:0]            rd_addr;
    logic                                 wr_en;
    logic [fpa_pkg::IDX_W-1:0]            wr_addr;
    fpa_pkg::t_entry                      wr_data;
    logic [fpa_pkg::END_BITS-1:0]         pg_ext;
    logic [fpa_pkg::END_BITS-1:0]         pg_next;
    logic [fpa_pkg::END_BITS-1:0]         cur_b_ext;
    logic [fpa_pkg::IDX_W-1:0]            pos_val;

    assign cur       = fpa_pkg::t_entry'(rd_data);
    assign pg_ext    = {1'b0, r_pg};
    assign pg_next   = pg_ext + fpa_pkg::END_BITS'(1);
    assign cur_b_ext = {1'b0, cur.b};

    // read port: scan fetch or shift source
    always_comb begin
        rd_en   = i_cmd.fetch_first | i_cmd.fetch_next | i_cmd.move_rd;
        rd_addr = '0;
        if (i_cmd.fetch_next) begin
            rd_addr = r_idx + fpa_pkg::IDX_W'(1);
        end else if (i_cmd.move_rd) begin
            rd_addr = r_dir_up ? (r_k - fpa_pkg::IDX_W'(1)) : (r_k + fpa_pkg::IDX_W'(1));
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx;
        wr_data = cur;
        case (i_cmd.wr_sel)
            fpa_pkg::WR_CUR_INC: begin
                wr_data.b = cur.b + fpa_pkg::PAGE_NUMBER_BITS'(1);
            end
            fpa_pkg::WR_CUR_BEGIN: begin
                wr_data.b = r_pg;
            end
            fpa_pkg::WR_PREV_END: begin
                wr_addr   = r_idx - fpa_pkg::IDX_W'(1);
                wr_data.b = r_prev.b;
                wr_data.e = pg_next;
            end
            fpa_pkg::WR_CUR_END: begin
                wr_data.e = pg_next;
            end
            fpa_pkg::WR_MOVE: begin
                wr_addr = r_k;
            end
            fpa_pkg::WR_NEW: begin
                wr_addr   = r_pos;
                wr_data.b = r_pg;
                wr_data.e = pg_next;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    fpa_ram #(
        .WIDTH(fpa_pkg::ENTRY_W),
        .DEPTH(fpa_pkg::MAX_EXTENTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        case (i_cmd.pos_sel)
            fpa_pkg::POS_IDX:  pos_val = r_idx;
            fpa_pkg::POS_IDX1: pos_val = r_idx + fpa_pkg::IDX_W'(1);
            default:           pos_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + fpa_pkg::CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - fpa_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_pg     <= i_page_number;
            r_grant  <= '0;
            r_status <= fpa_pkg::STATUS_OK;
        end
        if (i_cmd.fetch_first) begin
            r_idx <= '0;
        end else if (i_cmd.fetch_next) begin
            r_idx  <= r_idx + fpa_pkg::IDX_W'(1);
            r_prev <= cur;
        end
        if (i_cmd.set_grant) begin
            r_grant <= cur.b;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.set_pos) begin
            r_pos <= pos_val;
        end
        if (i_cmd.start_up) begin
            r_k      <= r_count[fpa_pkg::IDX_W-1:0];
            r_dir_up <= 1'b1;
        end else if (i_cmd.start_down) begin
            r_k      <= '0;
            r_dir_up <= 1'b0;
        end else if (i_cmd.step_k) begin
            r_k <= r_dir_up ? (r_k - fpa_pkg::IDX_W'(1)) : (r_k + fpa_pkg::IDX_W'(1));
        end
    end

    always_comb begin
        o_flags.alloc         = (r_op == fpa_pkg::OP_ALLOC);
        o_flags.cnt_zero      = (r_count == '0);
        o_flags.cnt_full      = (r_count >= fpa_pkg::CNT_W'(fpa_pkg::MAX_EXTENTS));
        o_flags.idx_zero      = (r_idx == '0);
        o_flags.idx_last      = ({1'b0, r_idx} + fpa_pkg::CNT_W'(1) == r_count);
        o_flags.below_first   = (r_pg < cur.b);
        o_flags.below_adj     = (cur.b - fpa_pkg::PAGE_NUMBER_BITS'(1) == r_pg);
        o_flags.empties       = (cur_b_ext + fpa_pkg::END_BITS'(1) >= cur.e);
        o_flags.gap_hit       = (r_prev.e <= pg_ext) && (r_pg < cur.b);
        o_flags.prev_end_eq   = (r_prev.e == pg_ext);
        o_flags.cur_right_adj = (cur.b != '0) &&
                                (cur.b - fpa_pkg::PAGE_NUMBER_BITS'(1) == r_pg);
        o_flags.cur_end_eq    = (cur.e == pg_ext);
        o_flags.move_done     = r_dir_up ? (r_k == r_pos)
                                         : ({1'b0, r_k} + fpa_pkg::CNT_W'(1) >= r_count);
        o_flags.dir_up        = r_dir_up;
    end

    assign o_granted_page   = r_grant;
    assign o_status         = r_status;
    assign o_extents_in_use = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fpa_pkg::CNT_W'(fpa_pkg::MAX_EXTENTS))
        else $error("extent count above table size");

    a_no_inc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> !o_flags.cnt_full)
        else $error("insert into full table");

    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> !o_flags.cnt_zero)
        else $error("remove from empty table");
endmodule

FILE: src/fpa_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free page extent allocator controller
// Sequences scan, in-place update, table shifts and the response handshake.
// ---------------------------------------------------------------------------
module fpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  fpa_pkg::t_flags i_flags,
    output fpa_pkg::t_cmd   o_cmd
);
    typedef enum logic [3:0] {
        ACT_GRANT_REMOVE,
        ACT_GRANT_INC,
        ACT_WR_CUR_BEGIN,
        ACT_WR_PREV_END,
        ACT_WR_CUR_END,
        ACT_INS_ZERO,
        ACT_INS_IDX,
        ACT_INS_NEXT,
        ACT_NEXT
    } t_act;

    fpa_pkg::t_state r_state;
    fpa_pkg::t_state n_state;
    t_act            act;
    logic            act_ins;

    // decision on the entry just read (and the one before it)
    always_comb begin
        if (i_flags.alloc) begin
            act = i_flags.empties ? ACT_GRANT_REMOVE : ACT_GRANT_INC;
        end else if (i_flags.idx_zero && i_flags.below_first) begin
            act = i_flags.below_adj ? ACT_WR_CUR_BEGIN : ACT_INS_ZERO;
        end else if (!i_flags.idx_zero && i_flags.gap_hit) begin
            if (i_flags.prev_end_eq) begin
                act = ACT_WR_PREV_END;
            end else if (i_flags.cur_right_adj) begin
                act = ACT_WR_CUR_BEGIN;
            end else begin
                act = ACT_INS_IDX;
            end
        end else if (i_flags.idx_last) begin
            act = i_flags.cur_end_eq ? ACT_WR_CUR_END : ACT_INS_NEXT;
        end else begin
            act = ACT_NEXT;
        end
    end

    assign act_ins = (act == ACT_INS_ZERO) || (act == ACT_INS_IDX) || (act == ACT_INS_NEXT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpa_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fpa_pkg::S_START;
            end
            fpa_pkg::S_START: begin
                if (!i_flags.cnt_zero) begin
                    n_state = fpa_pkg::S_EVAL;
                end else if (i_flags.alloc) begin
                    n_state = fpa_pkg::S_DONE;
                end else begin
                    n_state = fpa_pkg::S_MOVE_RD;
                end
            end
            fpa_pkg::S_EVAL: begin
                if (act == ACT_NEXT) begin
                    n_state = fpa_pkg::S_EVAL;
                end else if (act == ACT_GRANT_REMOVE) begin
                    n_state = fpa_pkg::S_MOVE_RD;
                end else if (act_ins && !i_flags.cnt_full) begin
                    n_state = fpa_pkg::S_MOVE_RD;
                end else begin
                    n_state = fpa_pkg::S_DONE;
                end
            end
            fpa_pkg::S_MOVE_RD: begin
                if (!i_flags.move_done) begin
                    n_state = fpa_pkg::S_MOVE_WR;
                end else if (i_flags.dir_up) begin
                    n_state = fpa_pkg::S_PLACE;
                end else begin
                    n_state = fpa_pkg::S_DONE;
                end
            end
            fpa_pkg::S_MOVE_WR: n_state = fpa_pkg::S_MOVE_RD;
            fpa_pkg::S_PLACE:   n_state = fpa_pkg::S_DONE;
            fpa_pkg::S_DONE: begin
                if (i_out_ready) n_state = fpa_pkg::S_IDLE;
            end
            default: n_state = fpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.wr_sel = fpa_pkg::WR_NONE;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        case (r_state)
            fpa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fpa_pkg::S_START: begin
                if (!i_flags.cnt_zero) begin
                    o_cmd.fetch_first = 1'b1;
                end else if (i_flags.alloc) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = fpa_pkg::STATUS_NO_FREE;
                end else begin
                    o_cmd.set_pos  = 1'b1;
                    o_cmd.pos_sel  = fpa_pkg::POS_ZERO;
                    o_cmd.start_up = 1'b1;
                end
            end
            fpa_pkg::S_EVAL: begin
                case (act)
                    ACT_GRANT_REMOVE: begin
                        o_cmd.set_grant  = 1'b1;
                        o_cmd.start_down = 1'b1;
                    end
                    ACT_GRANT_INC: begin
                        o_cmd.set_grant = 1'b1;
                        o_cmd.wr_sel    = fpa_pkg::WR_CUR_INC;
                    end
                    ACT_WR_CUR_BEGIN: o_cmd.wr_sel = fpa_pkg::WR_CUR_BEGIN;
                    ACT_WR_PREV_END:  o_cmd.wr_sel = fpa_pkg::WR_PREV_END;
                    ACT_WR_CUR_END:   o_cmd.wr_sel = fpa_pkg::WR_CUR_END;
                    ACT_NEXT:         o_cmd.fetch_next = 1'b1;
                    default: begin
                        // insertion; a full table drops the page
                        if (i_flags.cnt_full) begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = fpa_pkg::STATUS_FULL;
                        end else begin
                            o_cmd.set_pos  = 1'b1;
                            o_cmd.start_up = 1'b1;
                            if (act == ACT_INS_IDX) begin
                                o_cmd.pos_sel = fpa_pkg::POS_IDX;
                            end else if (act == ACT_INS_NEXT) begin
                                o_cmd.pos_sel = fpa_pkg::POS_IDX1;
                            end else begin
                                o_cmd.pos_sel = fpa_pkg::POS_ZERO;
                            end
                        end
                    end
                endcase
            end
            fpa_pkg::S_MOVE_RD: begin
                if (!i_flags.move_done) begin
                    o_cmd.move_rd = 1'b1;
                end else if (!i_flags.dir_up) begin
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            fpa_pkg::S_MOVE_WR: begin
                o_cmd.wr_sel = fpa_pkg::WR_MOVE;
                o_cmd.step_k = 1'b1;
            end
            fpa_pkg::S_PLACE: begin
                o_cmd.wr_sel  = fpa_pkg::WR_NEW;
                o_cmd.cnt_inc = 1'b1;
            end
            fpa_pkg::S_DONE: begin
                o_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("accepting while a response is pending");

    a_done_after_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpa_pkg::S_PLACE) |=> o_out_valid)
        else $error("insert not followed by response");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == fpa_pkg::S_START))
        else $error("accepted request not started");
endmodule

FILE: src/free_page_extent_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Free page extent allocator
// Ascending table of free page extents [begin,end) with allocate and free.
// ---------------------------------------------------------------------------
// One request at a time: a request is taken only when the previous response
// has been transferred. Allocate either updates the lowest extent in place or,
// when the lowest extent empties, shifts the table down. Free scans the table
// one entry per cycle and, when a new extent must be inserted, shifts the
// entries above it up, each one read and then written back through the
// registered-read extent RAM; the longest free is an insert at the front of a
// table holding MAX_EXTENTS-1 extents. No clearing pass after reset: the table
// is valid only below the extent count.
module free_page_extent_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);
    fpa_pkg::t_cmd   cmd;
    fpa_pkg::t_flags flags;

    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    fpa_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_req.operation),
        .i_page_number   (i_req.page_number),
        .o_flags         (flags),
        .o_granted_page  (o_rsp.granted_page),
        .o_status        (o_rsp.status),
        .o_extents_in_use(o_rsp.extents_in_use)
    );
endmodule
